FILE: hw/rtl/mbps_pkg.sv
// Shared types, constants and helpers for the masked byte pattern search.
// Used by the cell, the top level and the checker; depends on nothing else.
`default_nettype none

package mbps_pkg;

  localparam int unsigned MaxPatLen = 32;
  localparam int unsigned CellIdxW  = $clog2(MaxPatLen);
  localparam int unsigned LenW      = 6;
  localparam int unsigned CntW      = 64;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumPatWords = (MaxPatLen + 7) / 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_WORD0 = 3'd0,
    CFG_PAT_WORD1 = 3'd1,
    CFG_PAT_WORD2 = 3'd2,
    CFG_PAT_WORD3 = 3'd3,
    CFG_CARE_MASK = 3'd4,
    CFG_PAT_LEN   = 3'd5,
    CFG_BASE      = 3'd6
  } cfg_idx_e;

  typedef logic [NumPatWords-1:0][63:0] pat_words_t;

  // What one window cell compares its byte against.
  typedef struct packed {
    logic       active;
    logic       care;
    logic [7:0] pat_byte;
  } cell_cmp_t;

  function automatic logic [7:0] pattern_byte(input pat_words_t words,
                                              input logic [CellIdxW-1:0] k);
    logic [CellIdxW-4:0] word_sel;
    logic [2:0]          byte_sel;
    word_sel = k[CellIdxW-1:3];
    byte_sel = k[2:0];
    return words[word_sel][{byte_sel, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mbps_cell.sv
// One window cell: holds one region byte, passes it on to the next cell on
// every accepted item and compares it against its selected pattern byte.
// Depends on mbps_pkg.
`default_nettype none

module mbps_cell (
  input  wire logic                clk,
  input  wire logic                shift_en,
  input  wire logic [7:0]          byte_in,
  input  wire mbps_pkg::cell_cmp_t cmp,
  output logic [7:0]               byte_q,
  output logic                     ok
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

  // Cells beyond the pattern length and wildcard positions always pass.
  assign ok = !cmp.active || !cmp.care || (byte_q == cmp.pat_byte);

endmodule

`default_nettype wire

FILE: hw/rtl/masked_byte_pattern_search_top.sv
// Masked byte pattern search. The block takes one region byte per clock into a
// 32-cell shift window and compares every cell against its pattern byte in
// parallel, so it sustains one item per cycle; a result is registered after the
// byte that causes it enters the window, and only a stalled output slows intake.
// Depends on mbps_pkg and mbps_cell.
`default_nettype none

module masked_byte_pattern_search_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mbps_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [mbps_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                found,
  output logic [mbps_pkg::AddrW-1:0]          match_address
);

  mbps_pkg::pat_words_t              pat_words;
  logic [mbps_pkg::MaxPatLen-1:0]    care_mask;
  logic [mbps_pkg::LenW-1:0]         pat_len;
  logic [mbps_pkg::AddrW-1:0]        region_base;

  logic [7:0]                        win [mbps_pkg::MaxPatLen];
  logic [mbps_pkg::MaxPatLen-1:0]    cell_ok;

  logic                              pend;
  logic                              pend_last;
  logic                              done;
  logic [mbps_pkg::CntW-1:0]         seen;
  logic [mbps_pkg::CntW-1:0]         seen_base;
  logic [mbps_pkg::CntW-1:0]         seen_next;

  logic slot_free;
  logic eval;
  logic accept;
  logic len_ok;
  logic hit;
  logic emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_words   <= '0;
      care_mask   <= '0;
      pat_len     <= '0;
      region_base <= '0;
    end else if (cfg_we) begin
      case (mbps_pkg::cfg_idx_e'(cfg_index))
        mbps_pkg::CFG_PAT_WORD0: pat_words[0] <= cfg_data;
        mbps_pkg::CFG_PAT_WORD1: pat_words[1] <= cfg_data;
        mbps_pkg::CFG_PAT_WORD2: pat_words[2] <= cfg_data;
        mbps_pkg::CFG_PAT_WORD3: pat_words[3] <= cfg_data;
        mbps_pkg::CFG_CARE_MASK: care_mask    <= cfg_data[mbps_pkg::MaxPatLen-1:0];
        mbps_pkg::CFG_PAT_LEN:   pat_len      <= cfg_data[mbps_pkg::LenW-1:0];
        mbps_pkg::CFG_BASE:      region_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid || !out_stall;
  assign eval      = pend && slot_free;
  assign in_stall  = pend && !slot_free;
  assign accept    = in_valid && !in_stall;

  // Cell i holds the byte seen i items ago; it lines up with pattern byte
  // pat_len-1-i. Bytes older than the region are never read, because the
  // match also needs at least pat_len bytes seen.
  for (genvar g = 0; g < mbps_pkg::MaxPatLen; g++) begin : g_cell
    logic [7:0]              byte_in;
    logic [mbps_pkg::LenW-1:0] jj;
    mbps_pkg::cell_cmp_t     cmp;

    if (g == 0) begin : g_head
      assign byte_in = data_byte;
    end else begin : g_link
      assign byte_in = win[g-1];
    end

    always_comb begin
      jj           = pat_len - mbps_pkg::LenW'(g) - mbps_pkg::LenW'(1);
      cmp.active   = mbps_pkg::LenW'(g) < pat_len;
      cmp.care     = care_mask[jj[mbps_pkg::CellIdxW-1:0]];
      cmp.pat_byte = mbps_pkg::pattern_byte(pat_words, jj[mbps_pkg::CellIdxW-1:0]);
    end

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (byte_in),
      .cmp      (cmp),
      .byte_q   (win[g]),
      .ok       (cell_ok[g])
    );
  end

  always_comb begin
    seen_base = (eval && pend_last) ? '0 : seen;
    seen_next = (seen_base == '1) ? seen_base : seen_base + mbps_pkg::CntW'(1);
  end

  assign len_ok = (pat_len != '0) && (pat_len <= mbps_pkg::LenW'(mbps_pkg::MaxPatLen));
  assign hit    = (region_base != '0) && len_ok &&
                  (seen >= mbps_pkg::CntW'(pat_len)) && (&cell_ok);
  assign emit   = eval && !done && (hit || pend_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      pend_last <= 1'b0;
      done      <= 1'b0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend      <= 1'b1;
        pend_last <= last_byte;
        seen      <= seen_next;
      end else if (eval) begin
        pend <= 1'b0;
        if (pend_last) begin
          seen <= '0;
        end
      end

      if (eval) begin
        if (pend_last) begin
          done <= 1'b0;
        end else if (!done && hit) begin
          done <= 1'b1;
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found         <= hit;
      match_address <= hit ? region_base + (seen - mbps_pkg::CntW'(pat_len)) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbps_checker.sv
// Port-level checker for the masked byte pattern search, bound to the top.
// Depends on mbps_pkg and masked_byte_pattern_search_top.
`default_nettype none

module mbps_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          found,
  input wire logic [mbps_pkg::AddrW-1:0]    match_address
);

  // A not-found item always carries a zero address.
  a_miss_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == '0)
    else $error("not-found item with nonzero address");

  // The input only waits while a result is held back downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_address))
    else $error("stalled result changed");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind masked_byte_pattern_search_top mbps_checker u_mbps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found         (found),
  .match_address (match_address)
);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_search_top: streams byte regions through the
// block and checks each found/not-found report against a cycle-free predictor.
// Depends on mbps_pkg and the block's RTL.

module testbench;

  localparam int ItemGoal   = 1550;
  localparam int CycleLimit = 400_000;

  typedef struct packed {
    logic        found;
    logic [63:0] address;
  } report_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [mbps_pkg::CfgIdxW-1:0]  cfg_index;
  logic [mbps_pkg::CfgDataW-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              found;
  logic [mbps_pkg::AddrW-1:0]  match_address;

  // Predictor copy of the registers and the region state.
  logic [63:0] pat_words [4];
  logic [31:0] care_bits;
  logic [5:0]  pat_len;
  logic [63:0] base_addr;
  logic [7:0]  recent_bytes [32];
  logic [63:0] region_count;
  logic        match_reported;

  report_t pending_reports [$];
  int      failures;
  int      bytes_fed;
  int      cycles;
  logic    steady;

  masked_byte_pattern_search_top dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] pat_byte_at(input int k);
    return pat_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic logic [7:0] fill_byte(input bit narrow);
    return narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  task automatic clear_region();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    region_count   = 64'd0;
    match_reported = 1'b0;
  endtask

  // Advances the predicted search by one accepted byte.
  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    int n;
    logic hit;
    report_t r;
    n = int'(pat_len);
    if (match_reported) begin
      if (is_last) clear_region();
      return;
    end
    for (int i = 31; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
    recent_bytes[0] = b;
    if (region_count != '1) region_count++;
    hit = base_addr != 64'd0 && n >= 1 && n <= mbps_pkg::MaxPatLen &&
          region_count >= 64'(n);
    for (int j = 0; hit && j < n; j++) begin
      if (care_bits[j] && recent_bytes[n - 1 - j] != pat_byte_at(j)) hit = 1'b0;
    end
    if (hit) begin
      r.found   = 1'b1;
      r.address = base_addr + (region_count - 64'(n));
      pending_reports = {pending_reports, r};
      if (is_last) clear_region();
      else match_reported = 1'b1;
    end else if (is_last) begin
      r.found   = 1'b0;
      r.address = 64'd0;
      pending_reports = {pending_reports, r};
      clear_region();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pat_words[i]) pat_words[i] = 64'd0;
      care_bits = 32'd0;
      pat_len   = 6'd0;
      base_addr = 64'd0;
      clear_region();
    end else begin
      if (cfg_we) begin
        case (mbps_pkg::cfg_idx_e'(cfg_index))
          mbps_pkg::CFG_PAT_WORD0: pat_words[0] = cfg_data;
          mbps_pkg::CFG_PAT_WORD1: pat_words[1] = cfg_data;
          mbps_pkg::CFG_PAT_WORD2: pat_words[2] = cfg_data;
          mbps_pkg::CFG_PAT_WORD3: pat_words[3] = cfg_data;
          mbps_pkg::CFG_CARE_MASK: care_bits = cfg_data[31:0];
          mbps_pkg::CFG_PAT_LEN:   pat_len = cfg_data[5:0];
          mbps_pkg::CFG_BASE:      base_addr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) scan_byte(data_byte, last_byte);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: found=%0d match_address=%h", found, match_address);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          failures++;
        end
        if (match_address !== want.address) begin
          $error("match_address: expected %h, got %h", want.address, match_address);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 16);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic is_last);
    if (!steady) begin
      while ($urandom_range(99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_fed++;
  endtask

  task automatic send_region(input logic [7:0] bytes [$]);
    for (int i = 0; i < bytes.size(); i++) send_item(bytes[i], i == bytes.size() - 1);
  endtask

  // Stops input and waits until every expected report has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input mbps_pkg::cfg_idx_e idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic program_search(input logic [63:0] w0, input logic [63:0] w1,
                                input logic [63:0] w2, input logic [63:0] w3,
                                input logic [31:0] mask, input logic [5:0] len,
                                input logic [63:0] base);
    put_reg(mbps_pkg::CFG_PAT_WORD0, w0);
    put_reg(mbps_pkg::CFG_PAT_WORD1, w1);
    put_reg(mbps_pkg::CFG_PAT_WORD2, w2);
    put_reg(mbps_pkg::CFG_PAT_WORD3, w3);
    put_reg(mbps_pkg::CFG_CARE_MASK, {32'd0, mask});
    put_reg(mbps_pkg::CFG_PAT_LEN, {58'd0, len});
    put_reg(mbps_pkg::CFG_BASE, base);
    cfg_we <= 1'b0;
    // Let the predictor hold the new values before regions are built.
    @(posedge clk);
  endtask

  // With all registers at reset the pattern length is zero, so nothing matches.
  task automatic test_reset_defaults();
    send_region('{8'h00, 8'hFF});
  endtask

  // Pattern AA ?? CC with the middle byte a wildcard.
  task automatic test_directed_matches();
    settle();
    program_search(64'h0000_0000_00CC_BBAA, 64'd0, 64'd0, 64'd0, 32'h5, 6'd3, 64'h1000);
    send_region('{8'hAA, 8'h00, 8'hCC});
    send_region('{8'h11, 8'hAA, 8'hFF, 8'hCC, 8'h22, 8'h33});
    send_region('{8'hAA, 8'hBB});
  endtask

  task automatic test_zero_base();
    settle();
    program_search(64'h0000_0000_00CC_BBAA, 64'd0, 64'd0, 64'd0, 32'h5, 6'd3, 64'd0);
    send_region('{8'hAA, 8'h00, 8'hCC});
  endtask

  // The registers change halfway through a region; the new ones apply at once.
  task automatic test_mid_region_change();
    settle();
    program_search(64'h0000_0000_00CC_BBAA, 64'd0, 64'd0, 64'd0, 32'h5, 6'd3, 64'h2000);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    settle();
    program_search(64'd0, 64'd0, 64'd0, 64'd0, 32'h0, 6'd1, 64'h2000);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_oversize_length();
    settle();
    program_search(64'd0, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF, 6'd33, 64'h10);
    send_region('{8'h00, 8'h00});
  endtask

  task automatic send_search_region(input bit narrow);
    logic [7:0] bytes [$];
    int kind, span, pre, post, j, k;
    kind = $urandom_range(9);
    span = (pat_len >= 1 && pat_len <= mbps_pkg::MaxPatLen) ? int'(pat_len)
                                                             : $urandom_range(1, 6);
    pre  = ($urandom_range(3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 4);
    post = $urandom_range(0, 6);
    for (j = 0; j < pre; j++) bytes = {bytes, fill_byte(narrow)};
    if (kind <= 7) begin
      for (j = 0; j < span; j++) begin
        bytes = {bytes, care_bits[j] ? pat_byte_at(j) : fill_byte(narrow)};
      end
      // Broken sequence: spoil one byte that must match.
      if (kind >= 6) begin
        k = $urandom_range(span - 1);
        j = 0;
        while (j < span && !care_bits[(k + j) % span]) j++;
        if (j < span) bytes[pre + (k + j) % span] ^= 8'($urandom_range(1, 255));
      end
    end else begin
      for (j = $urandom_range(1, 16); j > 0; j--) bytes = {bytes, fill_byte(narrow)};
    end
    for (j = 0; j < post; j++) bytes = {bytes, fill_byte(narrow)};
    send_region(bytes);
  endtask

  task automatic test_random_search();
    logic [63:0] words [4];
    logic [63:0] base;
    logic [31:0] mask;
    logic [5:0]  len;
    bit narrow;
    for (int p = 0; bytes_fed < ItemGoal; p++) begin
      settle();
      narrow = (p % 3 == 0);
      steady = (p >= 5 && p <= 8);
      foreach (words[i]) begin
        words[i] = {$urandom, $urandom};
        if (narrow) words[i] &= 64'h0303_0303_0303_0303;
      end
      case (p % 8)
        0: len = 6'd32;
        1: len = 6'd1;
        2: len = 6'($urandom_range(33, 63));
        3: len = 6'd0;
        default: len = ($urandom_range(3) == 0) ? 6'($urandom_range(1, 32))
                                                : 6'($urandom_range(1, 8));
      endcase
      case (p % 5)
        0: mask = 32'hFFFF_FFFF;
        1: mask = 32'd0;
        default: mask = $urandom;
      endcase
      case (p % 6)
        0: base = 64'd0;
        1: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
        2: base = 64'd1;
        default: base = {$urandom, $urandom};
      endcase
      program_search(words[0], words[1], words[2], words[3], mask, len, base);
      for (int r = $urandom_range(3, 8); r > 0; r--) send_search_region(narrow);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    steady    = 1'b0;
    bytes_fed = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_matches();
    test_zero_base();
    test_mid_region_change();
    test_oversize_length();
    test_random_search();
    settle();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cell.sv
hw/rtl/masked_byte_pattern_search_top.sv
hw/rtl/mbps_checker.sv
dv/testbench.sv
